[rtl/tdv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdv_pkg: shared types and constants of the textual date validator
// Month name tables, day counts, saturation limits and the item struct.
// ----------------------------------------------------------------------------
package tdv_pkg;

  // word selector codes
  typedef enum logic [1:0] {
    WORD_DAY   = 2'd0,
    WORD_MONTH = 2'd1,
    WORD_YEAR  = 2'd2
  } word_e;

  // one input beat as held in the input register
  typedef struct packed {
    logic [1:0] word_index;
    logic [7:0] ch;
    logic       end_of_word;
  } tdv_item_t;

  localparam int unsigned NumMonths = 12;
  localparam int unsigned NameBytes = 9;
  localparam int unsigned FebIndex  = 1;

  localparam logic [6:0]  DAY_SAT    = 7'd99;
  localparam logic [13:0] YEAR_SAT   = 14'd10000;
  localparam logic [13:0] YEAR_LIMIT = 14'd9999;
  localparam logic [3:0]  POS_SAT    = 4'd15;
  localparam logic [4:0]  LEAP_DAYS  = 5'd29;
  localparam logic [8:0]  MOD_BASE   = 9'd400;

  // names are right aligned: the first letter sits at byte (length - 1)
  localparam logic [8*NameBytes-1:0] MONTH_NAME [NumMonths] = '{
    72'("january"), 72'("february"), 72'("march"), 72'("april"),
    72'("may"), 72'("june"), 72'("july"), 72'("august"),
    72'("september"), 72'("october"), 72'("november"), 72'("december")
  };

  localparam logic [3:0] MONTH_LEN [NumMonths] = '{
    4'd7, 4'd8, 4'd5, 4'd5, 4'd3, 4'd4, 4'd4, 4'd6, 4'd9, 4'd7, 4'd8, 4'd8
  };

  localparam logic [4:0] MONTH_DAYS [NumMonths] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // letter of month m at position pos, valid only when pos < length
  function automatic logic [7:0] month_letter(input int unsigned m, input logic [3:0] pos);
    logic [3:0] sel;
    sel = 4'(MONTH_LEN[m] - 4'd1 - pos);
    return MONTH_NAME[m][8*sel +: 8];
  endfunction

endpackage
`default_nettype wire

[rtl/tdv_in_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdv_in_reg: input register of the date validator
// Captures one character beat and hands it to the core when the core takes it.
// ----------------------------------------------------------------------------
module tdv_in_reg import tdv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] word_index_i,
  input  wire logic [7:0] ch_i,
  input  wire logic       end_of_word_i,
  output logic            item_valid_o,
  output tdv_item_t       item_o,
  input  wire logic       item_take_i
);

  logic      valid_q, valid_d;
  tdv_item_t item_q;

  // free when empty or when the held beat leaves this cycle
  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{word_index: word_index_i, ch: ch_i, end_of_word: end_of_word_i};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

[rtl/tdv_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdv_core: date state update and verdict
// Updates the month match mask, day and year accumulators and digit flags,
// and on the last year character registers the verdict.
// ----------------------------------------------------------------------------
module tdv_core import tdv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       item_valid_i,
  input  wire tdv_item_t  item_i,
  output logic            item_take_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            is_date_o
);

  logic [11:0] cand_q, cand_d;
  logic [3:0]  pos_q, pos_d;
  logic [6:0]  day_q, day_d;
  logic [13:0] year_q, year_d;
  logic [8:0]  mod_q, mod_d;
  logic [1:0]  flags_q, flags_d;
  logic        out_valid_q, out_valid_d;
  logic        is_date_q;

  logic        is_digit, is_upper, produces, take;
  logic [3:0]  digit;
  logic [7:0]  lc;
  logic [9:0]  day_sum;
  logic [16:0] year_sum;
  logic [13:0] year_new;
  logic [11:0] mod_sum, mod_rem;
  logic [21:0] mod_prod;
  logic [3:0]  mod_quot;
  logic [8:0]  mod_new;
  logic [1:0]  flags_new;
  logic [11:0] keep, hit;
  logic        one_hit, leap, verdict;
  logic [4:0]  limit;

  // character classes
  assign is_digit = (item_i.ch inside {[8'h30:8'h39]});
  assign is_upper = (item_i.ch inside {[8'h41:8'h5A]});
  assign digit    = 4'(item_i.ch - 8'h30);
  assign lc       = is_upper ? 8'(item_i.ch + 8'd32) : item_i.ch;

  // day and year accumulators with saturation
  assign day_sum  = 10'(day_q) * 10'd10 + 10'(digit);
  assign year_sum = 17'(year_q) * 17'd10 + 17'(digit);
  assign year_new = (year_sum > 17'(YEAR_SAT)) ? YEAR_SAT : year_sum[13:0];

  // year modulo 400: reciprocal estimate, never high, then one correction
  assign mod_sum  = 12'(mod_q) * 12'd10 + 12'(digit);
  assign mod_prod = 22'(mod_sum) * 22'd655;
  assign mod_quot = mod_prod[21:18];
  assign mod_rem  = mod_sum - 12'(mod_quot) * 12'(MOD_BASE);
  assign mod_new  = (mod_rem >= 12'(MOD_BASE)) ? 9'(mod_rem - 12'(MOD_BASE)) : mod_rem[8:0];

  // month letters compared in parallel
  always_comb begin
    for (int unsigned m = 0; m < NumMonths; m++) begin
      keep[m] = (pos_q < MONTH_LEN[m]) && (month_letter(m, pos_q) == lc);
    end
  end

  assign flags_new = is_digit ? flags_q : (flags_q & 2'b01);

  // verdict from the state seen after this year character
  always_comb begin
    limit = '0;
    for (int unsigned m = 0; m < NumMonths; m++) begin
      hit[m] = cand_q[m] && (MONTH_LEN[m] == pos_q);
      if (hit[m]) begin
        limit = limit | MONTH_DAYS[m];
      end
    end
    leap = (mod_new[1:0] == 2'b00) &&
           (mod_new != 9'd100) && (mod_new != 9'd200) && (mod_new != 9'd300);
    if (hit[FebIndex] && leap) begin
      limit = LEAP_DAYS;
    end
  end

  assign one_hit = (hit != '0) && ((hit & (hit - 12'd1)) == '0);
  assign verdict = (flags_new == 2'b11) && (year_new <= YEAR_LIMIT) && one_hit &&
                   (day_q <= 7'(limit));

  // handshake towards the input register and the result register
  assign produces    = (item_i.word_index == WORD_YEAR) && item_i.end_of_word;
  assign take        = item_valid_i && (!produces || !out_valid_q || out_ready_i);
  assign item_take_o = take;

  // next state
  always_comb begin
    cand_d      = cand_q;
    pos_d       = pos_q;
    day_d       = day_q;
    year_d      = year_q;
    mod_d       = mod_q;
    flags_d     = flags_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      case (item_i.word_index)
        WORD_DAY: begin
          if (is_digit) begin
            day_d = (day_sum > 10'(DAY_SAT)) ? DAY_SAT : day_sum[6:0];
          end else begin
            flags_d = flags_q & 2'b10;
          end
        end
        WORD_MONTH: begin
          cand_d = cand_q & keep;
          if (pos_q < POS_SAT) begin
            pos_d = pos_q + 4'd1;
          end
        end
        WORD_YEAR: begin
          if (is_digit) begin
            year_d = year_new;
            mod_d  = mod_new;
          end
          flags_d = flags_new;
          if (item_i.end_of_word) begin
            out_valid_d = 1'b1;
            cand_d      = '1;
            pos_d       = '0;
            day_d       = '0;
            year_d      = '0;
            mod_d       = '0;
            flags_d     = 2'b11;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q      <= '1;
      pos_q       <= '0;
      day_q       <= '0;
      year_q      <= '0;
      mod_q       <= '0;
      flags_q     <= 2'b11;
      out_valid_q <= 1'b0;
    end else begin
      cand_q      <= cand_d;
      pos_q       <= pos_d;
      day_q       <= day_d;
      year_q      <= year_d;
      mod_q       <= mod_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take && produces) begin
      is_date_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_date_o   = is_date_q;

endmodule
`default_nettype wire

[rtl/text_date_validator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_date_validator_top: textual date validator
// Checks a date written as day, month-name and year words, one character a beat.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid_i / in_ready_o with word_index_i (0 day, 1 month,
//   2 year), ch_i and end_of_word_i. Selector 3 beats are taken and dropped.
//   Output channel: out_valid_o / out_ready_i with is_date_o, one beat for
//   each input beat that ends the year word.
//   Verdict path: the year's last character is held in the input register; the
//   update loads its verdict into the result register once that one is free.
//   Throughput: one character per cycle unless a second verdict waits, set by
//   the single update stage; the month names are matched in parallel and all
//   arithmetic is by constants. Reset: month mask all ones, flags set,
//   counters cleared; both registers empty.
//   Stall: while a verdict waits, non-verdict beats keep flowing; a second
//   verdict waits in the input register and in_ready_o drops until the
//   receiver takes the first one.
// ----------------------------------------------------------------------------
module text_date_validator_top import tdv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] word_index_i,
  input  wire logic [7:0] ch_i,
  input  wire logic       end_of_word_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            is_date_o
);

  logic      item_valid;
  logic      item_take;
  tdv_item_t item;

  // input register
  tdv_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_index_i (word_index_i),
    .ch_i         (ch_i),
    .end_of_word_i(end_of_word_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // state update and verdict register
  tdv_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_take_o (item_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_date_o   (is_date_o)
  );

endmodule
`default_nettype wire

[rtl/tdv_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdv_checker: port level checks of the date validator
// Watches the top level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module tdv_checker import tdv_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [1:0] word_index_i,
  input wire logic       end_of_word_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       is_date_o
);

  // a stalled verdict beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_date_o))
    else $error("verdict beat changed while stalled");

  // back pressure only comes from a stalled verdict
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting verdict");

  // a character that does not end the year word never raises a verdict
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (word_index_i != WORD_YEAR || !end_of_word_i)
    |=> ##1 !$rose(out_valid_o))
    else $error("verdict raised by a non-final character");

endmodule

bind text_date_validator_top tdv_checker u_tdv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .word_index_i (word_index_i),
  .end_of_word_i(end_of_word_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .is_date_o    (is_date_o)
);
`default_nettype wire

[sim/text_date_validator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_date_validator_top_tb: self-checking bench for the textual date validator
// Sends day, month-name and year words one character a beat and checks every
// verdict beat against a behavioural predictor kept inside the bench.
// ----------------------------------------------------------------------------
module text_date_validator_top_tb;
  import tdv_pkg::*;

  localparam int          ClkPeriod   = 10;
  localparam int          CycleLimit  = 400000;
  localparam int          DrainCycles = 8;
  localparam int          PhaseItems  = 370;
  localparam int          Predict     = -1;
  localparam logic [1:0]  WordUnused  = 2'd3;
  localparam int unsigned OrderPlain  = 0;
  localparam int unsigned OrderMonthFirst = 1;
  localparam int unsigned OrderMixed  = 2;
  localparam int unsigned FebMonth    = 1;
  localparam int unsigned DayCap      = 99;
  localparam int unsigned YearCap     = 10000;
  localparam int unsigned YearMax     = 9999;
  localparam int unsigned LeapCycle   = 400;
  localparam int unsigned LeapDays    = 29;
  localparam logic [3:0]  PosCap      = 4'd15;

  // idle and stall odds per phase, percent of cycles
  localparam int unsigned SendIdle [4] = '{0, 53, 0, 22};
  localparam int unsigned RecvStall[4] = '{0, 0, 53, 22};

  typedef byte unsigned text_q_t[$];

  // one directed date; '~' in a word stands for a zero byte
  typedef struct {
    string day_txt;
    string mon_txt;
    string year_txt;
    bit    month_first;
    int    verdict;
  } date_case_t;

  date_case_t date_cases[24] = '{
    '{"31",   "January",   "2024",   1'b0, 1},
    '{"29",   "february",  "2000",   1'b0, 1},
    '{"29",   "FEBRUARY",  "1900",   1'b0, 0},
    '{"29",   "feBruary",  "2024",   1'b0, 1},
    '{"29",   "february",  "2023",   1'b0, 0},
    '{"29",   "february",  "2100",   1'b0, 0},
    '{"29",   "february",  "0",      1'b0, 1},
    '{"0",    "may",       "9999",   1'b0, 1},
    '{"1",    "may",       "10000",  1'b0, 0},
    '{"31",   "april",     "2001",   1'b0, 0},
    '{"30",   "September", "0",      1'b0, 1},
    '{"1a",   "june",      "2000",   1'b0, 0},
    '{"1",    "june",      "20x0",   1'b0, 0},
    '{"",     "july",      "1999",   1'b0, 1},
    '{"5",    "",          "1999",   1'b0, 0},
    '{"5",    "marc",      "1999",   1'b0, 0},
    '{"5",    "marchx",    "1999",   1'b0, 0},
    '{"1~",   "m~y",       "19~9",   1'b0, 0},
    '{"\377", "august",    "1999",   1'b0, 0},
    '{"/3",   "october",   "20:0",   1'b0, 0},
    '{"0000000000000031", "december", "0000002000", 1'b0, Predict},
    '{"123",  "october",   "2020",   1'b0, Predict},
    '{"1",    "septemberseptember", "123456789", 1'b0, Predict},
    '{"30",   "november",  "2021",   1'b1, 1}
  };

  string       month_txt [12] = '{"january", "february", "march", "april", "may", "june",
                                  "july", "august", "september", "october", "november",
                                  "december"};
  int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // dut connections
  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [1:0] word_index  = 2'd0;
  logic [7:0] ch          = 8'd0;
  logic       end_of_word = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic       is_date;

  // predicted date state
  logic [11:0] live_months;
  logic [3:0]  month_pos;
  logic [6:0]  day_num;
  logic [13:0] year_num;
  logic [8:0]  year_rem;
  logic [1:0]  digits_ok;

  bit          verdict_q[$];
  bit          want_date;
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned junk_pct      = 0;
  int unsigned flip_pct      = 0;

  text_date_validator_top u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .word_index_i (word_index),
    .ch_i         (ch),
    .end_of_word_i(end_of_word),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .is_date_o    (is_date)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_date();
    live_months = '1;
    month_pos   = '0;
    day_num     = '0;
    year_num    = '0;
    year_rem    = '0;
    digits_ok   = 2'b11;
  endfunction

  function automatic bit judge_date();
    int unsigned hits;
    int unsigned found;
    int unsigned limit;
    bit          leap;
    hits  = 0;
    found = 0;
    if (digits_ok != 2'b11 || year_num > YearMax) return 1'b0;
    // exactly one surviving name of exactly the length seen
    for (int m = 0; m < 12; m++) begin
      if (live_months[m] && month_txt[m].len() == month_pos) begin
        found = m;
        hits++;
      end
    end
    if (hits != 1) return 1'b0;
    leap  = (year_rem % 4 == 0) && ((year_rem % 100 != 0) || year_rem == 0);
    limit = (found == FebMonth && leap) ? LeapDays : month_days[found];
    return day_num <= limit;
  endfunction

  function automatic void predict_char(input tdv_item_t b, output bit fired,
                                       output bit verdict);
    logic [7:0]  lc;
    bit          is_num;
    int unsigned d;
    int unsigned acc;
    fired   = 1'b0;
    verdict = 1'b0;
    is_num  = (b.ch >= "0") && (b.ch <= "9");
    d       = is_num ? b.ch - "0" : 0;
    case (b.word_index)
      WORD_DAY: begin
        if (is_num) begin
          acc     = day_num * 10 + d;
          day_num = 7'((acc > DayCap) ? DayCap : acc);
        end else begin
          digits_ok[0] = 1'b0;
        end
      end
      WORD_MONTH: begin
        // fold upper case only, then knock out names that differ here
        lc = (b.ch >= "A" && b.ch <= "Z") ? b.ch + 8'd32 : b.ch;
        for (int m = 0; m < 12; m++) begin
          if (!(month_pos < month_txt[m].len() && 8'(month_txt[m][month_pos]) == lc))
            live_months[m] = 1'b0;
        end
        if (month_pos != PosCap) month_pos = month_pos + 4'd1;
      end
      WORD_YEAR: begin
        if (is_num) begin
          acc      = year_num * 10 + d;
          year_num = 14'((acc > YearCap) ? YearCap : acc);
          year_rem = 9'((year_rem * 10 + d) % LeapCycle);
        end else begin
          digits_ok[1] = 1'b0;
        end
        if (b.end_of_word) begin
          fired   = 1'b1;
          verdict = judge_date();
          clear_date();
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic text_q_t to_text(string s);
    text_q_t t;
    for (int i = 0; i < s.len(); i++) t.push_back((s[i] == "~") ? 8'h00 : s[i]);
    return t;
  endfunction

  function automatic text_q_t num_text(int unsigned v, int unsigned zeros);
    text_q_t t;
    t = to_text($sformatf("%0d", v));
    repeat (zeros) t.push_front("0");
    return t;
  endfunction

  // drive one beat, hold it until taken, then update the prediction
  task automatic send_beat(input tdv_item_t b, input int forced);
    bit fired;
    bit verdict;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    word_index  <= b.word_index;
    ch          <= b.ch;
    end_of_word <= b.end_of_word;
    do @(posedge clk); while (!in_ready);
    predict_char(b, fired, verdict);
    if (fired) verdict_q.push_back((forced < 0) ? verdict : bit'(forced));
    if (b.word_index != WordUnused) items_sent++;
  endtask

  task automatic send_unused(input logic [7:0] c, input logic eow);
    tdv_item_t b;
    b.word_index  = WordUnused;
    b.ch          = c;
    b.end_of_word = eow;
    send_beat(b, Predict);
  endtask

  // one date: day and month words and the year prefix in the chosen order,
  // then the closing year character
  task automatic send_date(input text_q_t dw, input text_q_t mw, input text_q_t yw,
                           input int unsigned order, input int forced);
    tdv_item_t   b;
    byte unsigned year_last;
    int unsigned pick;
    int unsigned left [3];
    bit          flip;
    year_last = yw.pop_back();
    while (dw.size() + mw.size() + yw.size() != 0) begin
      left[0] = dw.size();
      left[1] = mw.size();
      left[2] = yw.size();
      if (order == OrderMixed) begin
        do pick = $urandom_range(0, 2); while (left[pick] == 0);
      end else if (order == OrderMonthFirst && left[1] != 0) begin
        pick = 1;
      end else begin
        pick = (left[0] != 0) ? 0 : (left[1] != 0) ? 1 : 2;
      end
      if ($urandom_range(0, 99) < junk_pct)
        send_unused(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      flip = $urandom_range(0, 99) < flip_pct;
      case (pick)
        0: begin
          b.word_index  = WORD_DAY;
          b.ch          = dw.pop_front();
          b.end_of_word = (dw.size() == 0) || flip;
        end
        1: begin
          b.word_index  = WORD_MONTH;
          b.ch          = mw.pop_front();
          b.end_of_word = (mw.size() == 0) || flip;
        end
        default: begin
          b.word_index  = WORD_YEAR;
          b.ch          = yw.pop_front();
          b.end_of_word = 1'b0;
        end
      endcase
      send_beat(b, Predict);
    end
    b.word_index  = WORD_YEAR;
    b.ch          = year_last;
    b.end_of_word = 1'b1;
    send_beat(b, forced);
  endtask

  // mostly well-formed dates near month and leap boundaries, some damaged
  task automatic random_date();
    text_q_t     dw;
    text_q_t     mw;
    text_q_t     yw;
    int unsigned m;
    int unsigned dv;
    int unsigned yv;
    int unsigned order;
    m = $urandom_range(0, 11);
    case ($urandom_range(0, 3))
      0:       dv = $urandom_range(0, 9);
      1:       dv = $urandom_range(10, 27);
      default: dv = $urandom_range(28, 32);
    endcase
    dw = num_text(dv, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
    // month name with random letter case
    mw = to_text(month_txt[m]);
    foreach (mw[i]) if ($urandom_range(0, 1)) mw[i] = mw[i] - 8'd32;
    case ($urandom_range(0, 5))
      0:       yv = $urandom_range(0, YearMax);
      1:       yv = 4 * $urandom_range(0, 2499);
      2:       yv = 100 * $urandom_range(0, 99);
      3:       yv = 400 * $urandom_range(0, 24);
      4:       yv = $urandom_range(9990, 10010);
      default: yv = $urandom_range(1890, 2110);
    endcase
    yw = num_text(yv, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0);

    // damage about a third of the dates
    if ($urandom_range(0, 99) >= 70) begin
      case ($urandom_range(0, 9))
        0: dw.delete();
        1: mw.delete();
        2: if (mw.size() != 0) void'(mw.pop_back());
        3: mw.push_back(8'($urandom_range("a", "z")));
        4: mw[$urandom_range(0, mw.size() - 1)] = 8'($urandom_range(0, 255));
        5: dw.insert($urandom_range(0, dw.size()), 8'($urandom_range(0, 255)));
        6: yw.insert($urandom_range(0, yw.size() - 1), 8'($urandom_range(0, 255)));
        7: dw = num_text($urandom_range(100, 99999), $urandom_range(0, 12));
        8: yw = num_text($urandom_range(10000, 999999999), $urandom_range(0, 3));
        default: begin
          mw.delete();
          repeat ($urandom_range(0, 20)) mw.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end

    junk_pct = ($urandom_range(0, 3) == 0) ? 10 : 0;
    flip_pct = ($urandom_range(0, 3) == 0) ? 20 : 0;
    case ($urandom_range(0, 9))
      0:       order = OrderMonthFirst;
      1:       order = OrderMixed;
      default: order = OrderPlain;
    endcase
    send_date(dw, mw, yw, order, Predict);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls and verdict checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("is_date: beat with no verdict pending, actual %0b", is_date);
        fail_count++;
      end else begin
        want_date = verdict_q.pop_front();
        if (is_date !== want_date) begin
          $error("is_date: expected %0b, actual %0b", want_date, is_date);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_end;
    clear_date();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed dates, each led by an ignored selector beat
    foreach (date_cases[i]) begin
      if (i % 2 == 0) send_unused(8'hFF, 1'b1);
      else            send_unused(8'h00, 1'b0);
      send_date(to_text(date_cases[i].day_txt), to_text(date_cases[i].mon_txt),
                to_text(date_cases[i].year_txt),
                date_cases[i].month_first ? OrderMonthFirst : OrderPlain,
                date_cases[i].verdict);
    end

    // random dates across the idle and stall phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SendIdle[p];
      stall_pct     = RecvStall[p];
      phase_end     = items_sent + PhaseItems;
      while (items_sent < phase_end) random_date();
    end
    in_valid <= 1'b0;

    // let outstanding verdicts drain
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tdv_pkg.sv
rtl/tdv_in_reg.sv
rtl/tdv_core.sv
rtl/text_date_validator_top.sv
rtl/tdv_checker.sv
sim/text_date_validator_top_tb.sv
